@@ src/pcl_pkg.sv @@
`timescale 1ns / 1ps

package pcl_pkg;

  localparam int ChanW    = 8;
  localparam int NumChans = 3;
  localparam int EntryW   = ChanW * NumChans;
  localparam int PairW    = 2 * EntryW;
  localparam int NumPairs = 8;
  localparam int PairIdxW = $clog2(NumPairs);
  localparam int EntryIdxW = PairIdxW + 1;
  localparam int CfgIdxW  = 8;
  localparam int WeightW  = ChanW + 1;
  localparam int ProdW    = ChanW + WeightW;
  localparam int Latency  = 5;

  localparam logic [ChanW-1:0] BriOff  = '0;
  localparam logic [ChanW-1:0] BriFull = '1;

  typedef logic [ChanW-1:0] chan_t;
  typedef chan_t [NumChans-1:0] rgb_t;

  // scale step: the product x * w shifted right by ChanW, kept to ChanW bits
  function automatic logic [ChanW-1:0] scale_hi(input chan_t x, input logic [WeightW-1:0] w);
    logic [ProdW-1:0] p;
    p = ProdW'(x) * ProdW'(w);
    return p[2*ChanW-1:ChanW];
  endfunction

endpackage

@@ src/palette16_color_lookup.sv @@
`timescale 1ns / 1ps

// channel  direction  signals                              handshake
// request  in         index, brightness                    start && !busy
// result   out        red, green, blue                     done, one cycle
// config   in         cfg_index, cfg_data                  cfg_valid && cfg_ready
//
// five register stages: palette read, blend multiply, blend add,
// brightness multiply, output; each request passes through them in order
// one request per cycle while not busy; busy is reset, registered
// the receiver cannot stall, so results leave at the pipeline rate
// reset clears the palette to black and empties the pipeline
module palette16_color_lookup (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [7:0]               index,
  input  logic [7:0]               brightness,
  output logic                     done,
  output logic [7:0]               red,
  output logic [7:0]               green,
  output logic [7:0]               blue,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [pcl_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [pcl_pkg::PairW-1:0]   cfg_data
);
  import pcl_pkg::*;

  logic [PairW-1:0] pal [NumPairs];
  logic [NumPairs-1:0] pal_vld;

  logic cfg_wr;
  logic acc;
  logic [EntryIdxW-1:0] ent_a;
  logic [EntryIdxW-1:0] ent_b;

  logic s1_vld, s2_vld, s3_vld, s4_vld;
  logic [3:0] s1_lo;
  logic [ChanW-1:0] s1_bri, s2_bri, s3_bri, s4_bri;
  logic s1_sel_a, s1_sel_b, s1_va, s1_vb;
  logic [PairW-1:0] s1_pa, s1_pb;

  rgb_t ea, eb;
  rgb_t s2_pa, s2_pb, s2_pa_next, s2_pb_next;
  rgb_t s3_v;
  rgb_t s4_v, s4_m, s4_m_next;
  rgb_t out_next, out_rgb;
  logic [ChanW-1:0] f2;
  logic [WeightW-1:0] wa, wb, wbri;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && (cfg_index < CfgIdxW'(NumPairs));
  assign acc = start && !busy;
  assign ent_a = index[7:4];
  assign ent_b = index[7:4] + EntryIdxW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // palette storage
  always_ff @(posedge clk) begin
    if (cfg_wr) begin
      pal[cfg_index[PairIdxW-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_vld <= '0;
    end else if (cfg_wr) begin
      pal_vld[cfg_index[PairIdxW-1:0]] <= 1'b1;
    end
  end

  // stage 1: palette read
  always_ff @(posedge clk) begin
    s1_pa    <= pal[ent_a[EntryIdxW-1:1]];
    s1_pb    <= pal[ent_b[EntryIdxW-1:1]];
    s1_va    <= pal_vld[ent_a[EntryIdxW-1:1]];
    s1_vb    <= pal_vld[ent_b[EntryIdxW-1:1]];
    s1_sel_a <= ent_a[0];
    s1_sel_b <= ent_b[0];
    s1_lo    <= index[3:0];
    s1_bri   <= brightness;
  end

  // stage 2: blend products
  always_comb begin
    ea = '0;
    eb = '0;
    if (s1_va) begin
      ea = s1_sel_a ? s1_pa[PairW-1:EntryW] : s1_pa[EntryW-1:0];
    end
    if (s1_vb) begin
      eb = s1_sel_b ? s1_pb[PairW-1:EntryW] : s1_pb[EntryW-1:0];
    end
    f2 = {s1_lo, 4'b0000};
    wa = WeightW'(1 << ChanW) - {1'b0, f2};
    wb = {1'b0, f2} + WeightW'(1);
    for (int c = 0; c < NumChans; c++) begin
      if (s1_lo == 4'd0) begin
        s2_pa_next[c] = ea[c];
        s2_pb_next[c] = '0;
      end else begin
        s2_pa_next[c] = scale_hi(ea[c], wa);
        s2_pb_next[c] = scale_hi(eb[c], wb);
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_pa  <= s2_pa_next;
    s2_pb  <= s2_pb_next;
    s2_bri <= s1_bri;
  end

  // stage 3: blend sum
  always_ff @(posedge clk) begin
    for (int c = 0; c < NumChans; c++) begin
      s3_v[c] <= s2_pa[c] + s2_pb[c];
    end
    s3_bri <= s2_bri;
  end

  // stage 4: brightness product
  always_comb begin
    wbri = {1'b0, s3_bri} + WeightW'(2);
    for (int c = 0; c < NumChans; c++) begin
      s4_m_next[c] = scale_hi(s3_v[c], wbri);
    end
  end

  always_ff @(posedge clk) begin
    s4_m   <= s4_m_next;
    s4_v   <= s3_v;
    s4_bri <= s3_bri;
  end

  // stage 5: brightness select
  always_comb begin
    for (int c = 0; c < NumChans; c++) begin
      if (s4_bri == BriFull) begin
        out_next[c] = s4_v[c];
      end else if (s4_bri == BriOff || s4_v[c] == '0) begin
        out_next[c] = '0;
      end else begin
        out_next[c] = s4_m[c] + ChanW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_vld) begin
      out_rgb <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      s1_vld <= acc;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      done   <= s4_vld;
    end
  end

  assign red   = out_rgb[0];
  assign green = out_rgb[1];
  assign blue  = out_rgb[2];

endmodule

@@ src/pcl_checker.sv @@
`timescale 1ns / 1ps

module pcl_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] brightness,
  input logic       done,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);
  import pcl_pkg::*;

  // every accepted request yields a result
  a_req_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("request without result");

  // no result without a request
  a_done_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Latency))
    else $error("result without request");

  // zero brightness gives black
  a_black: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && brightness == BriOff) |-> ##5
      (red == '0 && green == '0 && blue == '0))
    else $error("nonblack result at zero brightness");

endmodule

bind palette16_color_lookup pcl_checker u_pcl_checker (.*);
